@@ hw/rtl/asr_pkg.sv @@
// Shared types and constants for the second-order ambisonic X-axis rotator.
package asr_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_COS = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SIN = CFG_IDX_BITS'(1);

    // cycles from a register write until the coefficient bank is current
    localparam int SETTLE_CYC = 4;
    localparam int SETTLE_W   = 3;

    // coefficient bank slots
    localparam int CO_C     = 0;
    localparam int CO_S     = 1;
    localparam int CO_NS    = 2;
    localparam int CO_C2    = 3;
    localparam int CO_A     = 4;
    localparam int CO_NA    = 5;
    localparam int CO_H     = 6;
    localparam int CO_NH    = 7;
    localparam int CO_NB    = 8;
    localparam int CO_M66   = 9;
    localparam int CO_M88   = 10;
    localparam int NUM_COEF = 11;

    // lanes, one per rotated output channel
    localparam int LN_1      = 0;
    localparam int LN_2      = 1;
    localparam int LN_4      = 2;
    localparam int LN_5      = 3;
    localparam int LN_6      = 4;
    localparam int LN_7      = 5;
    localparam int LN_8      = 6;
    localparam int NUM_LANES = 7;
    localparam int NUM_TERMS = 3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_acn0;
        logic signed [SAMPLE_BITS-1:0] in_acn1;
        logic signed [SAMPLE_BITS-1:0] in_acn2;
        logic signed [SAMPLE_BITS-1:0] in_acn3;
        logic signed [SAMPLE_BITS-1:0] in_acn4;
        logic signed [SAMPLE_BITS-1:0] in_acn5;
        logic signed [SAMPLE_BITS-1:0] in_acn6;
        logic signed [SAMPLE_BITS-1:0] in_acn7;
        logic signed [SAMPLE_BITS-1:0] in_acn8;
    } t_in_frame;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_acn0;
        logic signed [SAMPLE_BITS-1:0] out_acn1;
        logic signed [SAMPLE_BITS-1:0] out_acn2;
        logic signed [SAMPLE_BITS-1:0] out_acn3;
        logic signed [SAMPLE_BITS-1:0] out_acn4;
        logic signed [SAMPLE_BITS-1:0] out_acn5;
        logic signed [SAMPLE_BITS-1:0] out_acn6;
        logic signed [SAMPLE_BITS-1:0] out_acn7;
        logic signed [SAMPLE_BITS-1:0] out_acn8;
    } t_out_frame;

endpackage

@@ hw/rtl/asr_coef.sv @@
// Coefficient bank: derives double-angle and second-order weights from cos/sin.
module asr_coef #(
    parameter int COEF_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic signed [COEF_BITS-1:0]           i_cos,
    input  logic signed [COEF_BITS-1:0]           i_sin,
    output logic [asr_pkg::NUM_COEF-1:0][COEF_BITS:0] o_coef
);
    import asr_pkg::*;

    localparam int CB = COEF_BITS;
    localparam int F  = CB - 1;
    localparam int CW = CB + 1;
    localparam int PW = 2 * CB;
    localparam int DW = 2 * CB + 2;
    localparam int MW = CB + 4;

    localparam logic [63:0] K34_FULL  = (64'd929887697 + (64'd1 << (29 - F))) >> (30 - F);
    localparam logic [63:0] K316_FULL = (64'd464943848 + (64'd1 << (29 - F))) >> (30 - F);
    localparam logic signed [CB-1:0] K34  = K34_FULL[CB-1:0];
    localparam logic signed [CB-1:0] K316 = K316_FULL[CB-1:0];

    localparam logic signed [PW:0]   RND_P = (PW+1)'(64'd1 << (F - 1));
    localparam logic signed [DW-1:0] RND_D = DW'(64'd1 << (F - 1));
    localparam logic signed [CB+1:0] ONE_S = (CB+2)'(64'd1 << F);
    localparam logic signed [MW-1:0] ONE_M = MW'(64'd1 << F);
    localparam logic signed [MW-1:0] TWO_M = MW'(2);

    // stage 1: squares and cross product
    logic signed [PW-1:0] r_cc, r_ss, r_cs;
    // stage 2: double-angle terms
    logic signed [CW-1:0] r_c2;
    logic signed [CB+1:0] r_s2;
    // stage 3: constant-weighted products
    logic signed [DW-1:0] r_pa, r_pb;
    logic [NUM_COEF-1:0][CW-1:0] r_coef;

    logic signed [PW:0]   n_diff, n_dbl, n_c2f, n_s2f;
    logic signed [CB+1:0] n_omc, n_hs;
    logic signed [DW-1:0] n_af, n_bf;
    logic signed [CW-1:0] n_a, n_b, n_h, n_c2, n_s, n_c;
    logic signed [MW-1:0] n_c2m, n_m66f, n_m88f;
    logic [NUM_COEF-1:0][CW-1:0] n_coef;

    always_comb begin
        n_diff = (PW+1)'(r_cc) - (PW+1)'(r_ss);
        n_dbl  = (PW+1)'(r_cs) <<< 1;
        n_c2f  = (n_diff + RND_P) >>> F;
        n_s2f  = (n_dbl + RND_P) >>> F;
        n_omc  = ONE_S - (CB+2)'(r_c2);
    end

    always_comb begin
        n_af   = (r_pa + RND_D) >>> F;
        n_bf   = (r_pb + RND_D) >>> F;
        n_a    = CW'(n_af);
        n_b    = CW'(n_bf);
        n_hs   = (r_s2 + (CB+2)'(1)) >>> 1;
        n_h    = CW'(n_hs);
        n_c2   = r_c2;
        n_c2m  = MW'(r_c2);
        n_m66f = (ONE_M + n_c2m + n_c2m + n_c2m + TWO_M) >>> 2;
        n_m88f = (ONE_M + ONE_M + ONE_M + n_c2m + TWO_M) >>> 2;
        n_c    = CW'(i_cos);
        n_s    = CW'(i_sin);

        n_coef           = '0;
        n_coef[CO_C]     = n_c;
        n_coef[CO_S]     = n_s;
        n_coef[CO_NS]    = -n_s;
        n_coef[CO_C2]    = n_c2;
        n_coef[CO_A]     = n_a;
        n_coef[CO_NA]    = -n_a;
        n_coef[CO_H]     = n_h;
        n_coef[CO_NH]    = -n_h;
        n_coef[CO_NB]    = -n_b;
        n_coef[CO_M66]   = CW'(n_m66f);
        n_coef[CO_M88]   = CW'(n_m88f);
    end

    always_ff @(posedge i_clk) begin
        r_cc   <= i_cos * i_cos;
        r_ss   <= i_sin * i_sin;
        r_cs   <= i_cos * i_sin;
        r_c2   <= CW'(n_c2f);
        r_s2   <= (CB+2)'(n_s2f);
        r_pa   <= K34 * r_s2;
        r_pb   <= K316 * n_omc;
        r_coef <= n_coef;
    end

    assign o_coef = r_coef;

endmodule

@@ hw/rtl/asr_lane.sv @@
// One rotation lane: three coefficient-by-sample products and their sum.
module asr_lane #(
    parameter int COEF_W = 17
) (
    input  logic                                                   i_clk,
    input  logic [asr_pkg::NUM_TERMS-1:0][COEF_W-1:0]              i_coef,
    input  logic [asr_pkg::NUM_TERMS-1:0][asr_pkg::SAMPLE_BITS-1:0] i_smp,
    output logic signed [COEF_W+asr_pkg::SAMPLE_BITS+1:0]          o_sum
);
    import asr_pkg::*;

    localparam int PW = COEF_W + SAMPLE_BITS;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] r_prod [NUM_TERMS];
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_sum;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NUM_TERMS; k++) begin
            n_sum = n_sum + SW'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_TERMS; k++) begin
            r_prod[k] <= $signed(i_coef[k]) * $signed(i_smp[k]);
        end
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

@@ hw/rtl/asr_merge.sv @@
// Output stage: rounds and saturates lane sums and assembles the result frame.
module asr_merge #(
    parameter int COEF_BITS = 16
) (
    input  logic                                                       i_clk,
    input  logic                                                       i_rst_n,
    input  logic                                                       i_vld,
    input  logic [asr_pkg::NUM_LANES-1:0][COEF_BITS+asr_pkg::SAMPLE_BITS+2:0] i_sum,
    input  logic signed [asr_pkg::SAMPLE_BITS-1:0]                     i_w,
    input  logic signed [asr_pkg::SAMPLE_BITS-1:0]                     i_x,
    output asr_pkg::t_out_frame                                        o_result,
    output logic                                                       o_strobe
);
    import asr_pkg::*;

    localparam int F  = COEF_BITS - 1;
    localparam int SW = COEF_BITS + SAMPLE_BITS + 3;

    localparam logic signed [SW-1:0] RND = SW'(64'd1 << (F - 1));
    localparam logic signed [SW-1:0] HI  = SW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [SW-1:0] LO  = -HI - SW'(1);

    logic signed [SW-1:0]          n_rnd [NUM_LANES];
    logic signed [SAMPLE_BITS-1:0] n_sat [NUM_LANES];
    t_out_frame                    n_result;
    t_out_frame                    r_result;
    logic                          r_strobe;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            n_rnd[k] = ($signed(i_sum[k]) + RND) >>> F;
            if (n_rnd[k] > HI) begin
                n_sat[k] = HI[SAMPLE_BITS-1:0];
            end else if (n_rnd[k] < LO) begin
                n_sat[k] = LO[SAMPLE_BITS-1:0];
            end else begin
                n_sat[k] = n_rnd[k][SAMPLE_BITS-1:0];
            end
        end
        n_result.out_acn0 = i_w;
        n_result.out_acn1 = n_sat[LN_1];
        n_result.out_acn2 = n_sat[LN_2];
        n_result.out_acn3 = i_x;
        n_result.out_acn4 = n_sat[LN_4];
        n_result.out_acn5 = n_sat[LN_5];
        n_result.out_acn6 = n_sat[LN_6];
        n_result.out_acn7 = n_sat[LN_7];
        n_result.out_acn8 = n_sat[LN_8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_vld;
        end
        r_result <= n_result;
    end

    assign o_result = r_result;
    assign o_strobe = r_strobe;

endmodule

@@ hw/rtl/ambisonic_second_order_rotation.sv @@
// Top level of the second-order ambisonic rotator about the X axis.
//
// Takes one nine-channel ACN frame per clock when start is high and busy is low, and
// returns the rotated frame on o_result with o_strobe high for one cycle; the receiver
// cannot stall. The frame passes through the lane pipeline: a registered multiply, a
// registered three-term sum, then a registered round/saturate stage.
// Writes to the cosine/sine registers go through a four-stage coefficient pipeline
// (squares, double-angle terms, constant-weighted products, final weights); busy is high
// after each write and after reset while that bank settles.
module ambisonic_second_order_rotation #(
    parameter int COEF_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  asr_pkg::t_in_frame                  i_frame,
    output asr_pkg::t_out_frame                 o_result,
    output logic                                o_strobe,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [asr_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [COEF_BITS-1:0]                i_cfg_data
);
    import asr_pkg::*;

    localparam int CW = COEF_BITS + 1;
    localparam int SW = CW + SAMPLE_BITS + 2;

    logic signed [COEF_BITS-1:0] r_cos, r_sin;
    logic [SETTLE_W-1:0]         r_settle;
    logic [1:0]                  r_vld;
    logic signed [SAMPLE_BITS-1:0] r_w [2];
    logic signed [SAMPLE_BITS-1:0] r_x [2];

    logic                        cfg_wr;
    logic                        accept;
    logic [NUM_COEF-1:0][CW-1:0] coef;
    logic [NUM_LANES-1:0][NUM_TERMS-1:0][CW-1:0]          lane_coef;
    logic [NUM_LANES-1:0][NUM_TERMS-1:0][SAMPLE_BITS-1:0] lane_smp;
    logic [NUM_LANES-1:0][SW-1:0]                          lane_sum;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign busy        = (r_settle != '0);
    assign accept      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= COEF_BITS'(32767);
            r_sin    <= '0;
            r_settle <= SETTLE_W'(SETTLE_CYC);
            r_vld    <= '0;
        end else begin
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_COS: r_cos <= i_cfg_data;
                    REG_SIN: r_sin <= i_cfg_data;
                    default: ;
                endcase
                r_settle <= SETTLE_W'(SETTLE_CYC);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
            r_vld <= {r_vld[0], accept};
        end
    end

    // W and X bypass the lanes; keep them aligned with the lane sums
    always_ff @(posedge i_clk) begin
        r_w[0] <= i_frame.in_acn0;
        r_x[0] <= i_frame.in_acn3;
        r_w[1] <= r_w[0];
        r_x[1] <= r_x[0];
    end

    asr_coef #(
        .COEF_BITS(COEF_BITS)
    ) u_coef (
        .i_clk (i_clk),
        .i_cos (r_cos),
        .i_sin (r_sin),
        .o_coef(coef)
    );

    // lane routing; two-term lanes get a zero third term
    always_comb begin
        lane_coef = '0;
        lane_smp  = '0;

        lane_coef[LN_1][0] = coef[CO_C];   lane_smp[LN_1][0] = i_frame.in_acn1;
        lane_coef[LN_1][1] = coef[CO_NS];  lane_smp[LN_1][1] = i_frame.in_acn2;

        lane_coef[LN_2][0] = coef[CO_S];   lane_smp[LN_2][0] = i_frame.in_acn1;
        lane_coef[LN_2][1] = coef[CO_C];   lane_smp[LN_2][1] = i_frame.in_acn2;

        lane_coef[LN_4][0] = coef[CO_C];   lane_smp[LN_4][0] = i_frame.in_acn4;
        lane_coef[LN_4][1] = coef[CO_NS];  lane_smp[LN_4][1] = i_frame.in_acn7;

        lane_coef[LN_7][0] = coef[CO_S];   lane_smp[LN_7][0] = i_frame.in_acn4;
        lane_coef[LN_7][1] = coef[CO_C];   lane_smp[LN_7][1] = i_frame.in_acn7;

        lane_coef[LN_5][0] = coef[CO_C2];  lane_smp[LN_5][0] = i_frame.in_acn5;
        lane_coef[LN_5][1] = coef[CO_NA];  lane_smp[LN_5][1] = i_frame.in_acn6;
        lane_coef[LN_5][2] = coef[CO_NH];  lane_smp[LN_5][2] = i_frame.in_acn8;

        lane_coef[LN_6][0] = coef[CO_A];   lane_smp[LN_6][0] = i_frame.in_acn5;
        lane_coef[LN_6][1] = coef[CO_M66]; lane_smp[LN_6][1] = i_frame.in_acn6;
        lane_coef[LN_6][2] = coef[CO_NB];  lane_smp[LN_6][2] = i_frame.in_acn8;

        lane_coef[LN_8][0] = coef[CO_H];   lane_smp[LN_8][0] = i_frame.in_acn5;
        lane_coef[LN_8][1] = coef[CO_NB];  lane_smp[LN_8][1] = i_frame.in_acn6;
        lane_coef[LN_8][2] = coef[CO_M88]; lane_smp[LN_8][2] = i_frame.in_acn8;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        asr_lane #(
            .COEF_W(CW)
        ) u_lane (
            .i_clk (i_clk),
            .i_coef(lane_coef[g]),
            .i_smp (lane_smp[g]),
            .o_sum (lane_sum[g])
        );
    end

    asr_merge #(
        .COEF_BITS(COEF_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[1]),
        .i_sum   (lane_sum),
        .i_w     (r_w[1]),
        .i_x     (r_x[1]),
        .o_result(o_result),
        .o_strobe(o_strobe)
    );

endmodule
